// ===== src/arm_ik_pkg.sv =====
package arm_ik_pkg;

   localparam int ANG_W      = 18;
   localparam int CFG_W      = 13;
   localparam int MINR_W     = 8;
   localparam int CSR_IDX_W  = 3;

   localparam int ARM_W      = 15;   // planar reach after the range check
   localparam int S2_W       = 29;   // u^2 + w^2
   localparam int LEN2_W     = 26;   // squared link length
   localparam int N_W        = 31;   // law of cosines numerator
   localparam int P_W        = 55;   // length^2 * s^2
   localparam int R_W        = 62;   // acos radicand, signed
   localparam int RAD_W      = 58;   // radicand bits when not negative
   localparam int ROOT2_W    = RAD_W / 2;

   localparam int ZW         = 26;   // CORDIC angle accumulator, 1/65536 degree
   localparam int FRAC_SHIFT = 16;

   localparam int REACH_LIMIT = 16384;

   localparam logic signed [ZW-1:0]    Z_90      = 26'sd5898240;
   localparam logic signed [ZW-1:0]    Z_ROUND   = 26'sd128;
   localparam logic signed [ANG_W-1:0] ANGLE_90  = 18'sd23040;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOULDER_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_ARM       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_ARM       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_OFFSET        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOOL_OFFSET     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_REACH_X     = 3'd6;

   localparam logic [CFG_W-1:0]  RST_BASE_HEIGHT     = 13'd1706;
   localparam logic [CFG_W-1:0]  RST_SHOULDER_OFFSET = 13'd211;
   localparam logic [CFG_W-1:0]  RST_LOWER_ARM       = 13'd2273;
   localparam logic [CFG_W-1:0]  RST_UPPER_ARM       = 13'd2541;
   localparam logic [CFG_W-1:0]  RST_Z_OFFSET        = 13'd1193;
   localparam logic [CFG_W-1:0]  RST_TOOL_OFFSET     = 13'd905;
   localparam logic [MINR_W-1:0] RST_MIN_REACH_X     = 8'd2;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [ZW-1:0] cordic_angle(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0:  a = 26'sd2949120;
         1:  a = 26'sd1740967;
         2:  a = 26'sd919879;
         3:  a = 26'sd466945;
         4:  a = 26'sd234379;
         5:  a = 26'sd117304;
         6:  a = 26'sd58666;
         7:  a = 26'sd29335;
         8:  a = 26'sd14668;
         9:  a = 26'sd7334;
         10: a = 26'sd3667;
         11: a = 26'sd1833;
         12: a = 26'sd917;
         13: a = 26'sd458;
         14: a = 26'sd229;
         15: a = 26'sd115;
         16: a = 26'sd57;
         17: a = 26'sd29;
         18: a = 26'sd14;
         19: a = 26'sd7;
         20: a = 26'sd4;
         21: a = 26'sd2;
         22: a = 26'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/arm_ik_delay.sv =====
module arm_ik_delay import arm_ik_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] sr_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) sr_ff[i] <= '0;
      end else begin
         sr_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) sr_ff[i] <= sr_ff[i-1];
      end
   end

   assign dout = sr_ff[DEPTH-1];

endmodule

// ===== src/arm_ik_isqrt.sv =====
module arm_ik_isqrt import arm_ik_pkg::*; #(
   parameter int W = 34
) (
   input  logic             clock,
   input  logic [W-1:0]     din,
   output logic [W/2-1:0]   root,
   output logic [W/2:0]     rem
);

   localparam int H  = W / 2;
   localparam int RM = H + 3;

   logic [W-1:0]  rad_ff  [0:H-2];
   logic [RM-1:0] rem_ff  [0:H-1];
   logic [H-1:0]  root_ff [0:H-1];

   // one root bit per stage, two radicand bits consumed per stage
   for (genvar k = 0; k < H; k++) begin : g_stage
      logic [W-1:0]  rad_src;
      logic [RM-1:0] rem_src;
      logic [H-1:0]  root_src;
      logic [RM-1:0] cand;
      logic [RM-1:0] trial;
      logic          ge;
      logic [RM-1:0] rem_in;
      logic [H-1:0]  root_in;

      if (k == 0) begin : g_first
         assign rad_src  = din;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      assign cand    = {rem_src[RM-3:0], rad_src[W-1 -: 2]};
      assign trial   = {{(RM-H-2){1'b0}}, root_src, 2'b01};
      assign ge      = (cand >= trial);
      assign rem_in  = ge ? (cand - trial) : cand;
      assign root_in = {root_src[H-2:0], ge};

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end

      if (k < H - 1) begin : g_rad
         always_ff @(posedge clock) begin
            rad_ff[k] <= {rad_src[W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[H-1];
   assign rem  = rem_ff[H-1][H:0];

endmodule

// ===== src/arm_ik_cordic.sv =====
module arm_ik_cordic import arm_ik_pkg::*; #(
   parameter int IN_W   = 18,
   parameter int STAGES = 16
) (
   input  logic                    clock,
   input  logic signed [IN_W-1:0]  din_y,
   input  logic signed [IN_W-1:0]  din_x,
   output logic signed [ANG_W-1:0] angle
);

   localparam int DW = IN_W + FRAC_SHIFT + 3;

   logic signed [DW-1:0]    x_ff [0:STAGES];
   logic signed [DW-1:0]    y_ff [0:STAGES];
   logic signed [ZW-1:0]    z_ff [0:STAGES];
   logic signed [ANG_W-1:0] angle_ff;

   logic signed [DW-1:0] xs, ys;
   logic signed [DW-1:0] x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;
   logic signed [ZW-1:0] zr;
   logic signed [ANG_W-1:0] angle_in;

   assign xs = {{3{din_x[IN_W-1]}}, din_x, {FRAC_SHIFT{1'b0}}};
   assign ys = {{3{din_y[IN_W-1]}}, din_y, {FRAC_SHIFT{1'b0}}};

   // fold the left half plane by a quarter turn
   always_comb begin
      if (xs[DW-1]) begin
         if (!ys[DW-1]) begin
            x0_in = ys;
            y0_in = -xs;
            z0_in = Z_90;
         end else begin
            x0_in = -ys;
            y0_in = xs;
            z0_in = -Z_90;
         end
      end else begin
         x0_in = xs;
         y0_in = ys;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x0_in;
      y_ff[0] <= y0_in;
      z_ff[0] <= z0_in;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [DW-1:0] dx, dy;
      logic signed [DW-1:0] xn_in, yn_in;
      logic signed [ZW-1:0] zn_in;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_comb begin
         if (!y_ff[i][DW-1]) begin
            xn_in = x_ff[i] + dx;
            yn_in = y_ff[i] - dy;
            zn_in = z_ff[i] + cordic_angle(i);
         end else begin
            xn_in = x_ff[i] - dx;
            yn_in = y_ff[i] + dy;
            zn_in = z_ff[i] - cordic_angle(i);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1] <= xn_in;
         y_ff[i+1] <= yn_in;
         z_ff[i+1] <= zn_in;
      end
   end

   // round to 1/256 degree
   assign zr       = z_ff[STAGES] + Z_ROUND;
   assign angle_in = zr[ANG_W+7:8];

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

// ===== src/arm_inverse_kinematics_3dof_top.sv =====
// Three-joint arm inverse kinematics. One target (req_pos_x/y/z, 1/16 mm) is
// taken at every clock edge where start is high; busy is always low, so a new
// item may follow in every cycle. Each result appears on the rsp_ ports for
// exactly one cycle with rsp_valid high. The pipeline runs through the
// square roots, pipelined with one root bit per stage (POS_WIDTH stages for
// the planar radius, 29 for each law of cosines root), and through the
// CORDIC chains of CORDIC_STAGES + 2 stages. Angles are 1/256 degree; when
// there is no real solution rsp_solution_ok is low and all angles are zero.
// Registers are written through the csr_ port, which is always ready, and
// must only be written while no item is in flight.
module arm_inverse_kinematics_3dof_top import arm_ik_pkg::*; #(
   parameter int POS_WIDTH     = 17,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        start,
   output logic                        busy,
   input  logic signed [POS_WIDTH-1:0] req_pos_x,
   input  logic signed [POS_WIDTH-1:0] req_pos_y,
   input  logic signed [POS_WIDTH-1:0] req_pos_z,

   output logic                        rsp_valid,
   output logic signed [ANG_W-1:0]     rsp_base_angle,
   output logic signed [ANG_W-1:0]     rsp_lower_arm_angle,
   output logic signed [ANG_W-1:0]     rsp_upper_arm_angle,
   output logic                        rsp_solution_ok,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data
);

   localparam int P     = POS_WIDTH;
   localparam int RW_W  = ((P > 15) ? P : 15) + 1;
   localparam int LC    = CORDIC_STAGES + 2;
   localparam int LAT   = P + CORDIC_STAGES + 39;

   localparam logic signed [RW_W-1:0] LIM_POS = RW_W'(REACH_LIMIT);
   localparam logic signed [RW_W-1:0] LIM_NEG = -LIM_POS;

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0]  base_height_ff, shoulder_offset_ff, lower_len_ff, upper_len_ff;
   logic [CFG_W-1:0]  z_offset_ff, tool_offset_ff;
   logic [MINR_W-1:0] min_reach_ff;
   logic [LEN2_W-1:0] lower_sq_ff, upper_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff     <= RST_BASE_HEIGHT;
         shoulder_offset_ff <= RST_SHOULDER_OFFSET;
         lower_len_ff       <= RST_LOWER_ARM;
         upper_len_ff       <= RST_UPPER_ARM;
         z_offset_ff        <= RST_Z_OFFSET;
         tool_offset_ff     <= RST_TOOL_OFFSET;
         min_reach_ff       <= RST_MIN_REACH_X;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_HEIGHT:     base_height_ff     <= csr_data;
            CSR_SHOULDER_OFFSET: shoulder_offset_ff <= csr_data;
            CSR_LOWER_ARM:       lower_len_ff       <= csr_data;
            CSR_UPPER_ARM:       upper_len_ff       <= csr_data;
            CSR_Z_OFFSET:        z_offset_ff        <= csr_data;
            CSR_TOOL_OFFSET:     tool_offset_ff     <= csr_data;
            CSR_MIN_REACH_X:     min_reach_ff       <= csr_data[MINR_W-1:0];
            default: ;
         endcase
      end
   end

   // link length squares are registered from the length registers
   always_ff @(posedge clock) begin
      lower_sq_ff <= lower_len_ff * lower_len_ff;
      upper_sq_ff <= upper_len_ff * upper_len_ff;
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // ---------------- stage 1: clamp x ----------------
   logic                v1_ff;
   logic signed [P-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [P-1:0] min_reach_s;
   logic                x_low;

   assign min_reach_s = $signed({{(P-MINR_W){1'b0}}, min_reach_ff});
   assign x_low       = (req_pos_x < min_reach_s);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
   end

   always_ff @(posedge clock) begin
      x1_ff <= x_low ? min_reach_s : req_pos_x;
      y1_ff <= req_pos_y;
      z1_ff <= req_pos_z;
   end

   logic signed [P:0]   y1_ext, ny1;
   logic [P:0]          ay1_full;
   logic [P-1:0]        ay1;
   logic                yzero1;

   assign y1_ext   = {y1_ff[P-1], y1_ff};
   assign ny1      = -y1_ext;
   assign ay1_full = y1_ff[P-1] ? ny1 : y1_ext;
   assign ay1      = ay1_full[P-1:0];
   assign yzero1   = (y1_ff == '0);

   // base angle atan2(x, -y)
   logic signed [ANG_W-1:0] base_c, base10;
   logic                    yzero10;

   arm_ik_cordic #(.IN_W(P + 1), .STAGES(CORDIC_STAGES)) u_cordic_base (
      .clock (clock),
      .din_y ({x1_ff[P-1], x1_ff}),
      .din_x (ny1),
      .angle (base_c)
   );

   arm_ik_delay #(.WIDTH(ANG_W), .DEPTH(P + 35)) u_dly_base (
      .clock (clock), .reset (reset), .din (base_c), .dout (base10)
   );

   arm_ik_delay #(.WIDTH(1), .DEPTH(P + CORDIC_STAGES + 37)) u_dly_yzero (
      .clock (clock), .reset (reset), .din (yzero1), .dout (yzero10)
   );

   // ---------------- stage 2: x^2 + y^2, vertical reach ----------------
   logic                   v2_ff;
   logic [2*P-1:0]         sq2_ff;
   logic signed [RW_W-1:0] w2_ff;
   logic [2*P-1:0]         xsq, ysq;

   assign xsq = x1_ff[P-1:0] * x1_ff[P-1:0];
   assign ysq = ay1 * ay1;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      sq2_ff <= xsq + ysq;
      w2_ff  <= $signed({{(RW_W-P){z1_ff[P-1]}}, z1_ff})
              + $signed({{(RW_W-CFG_W){1'b0}}, z_offset_ff})
              - $signed({{(RW_W-CFG_W){1'b0}}, base_height_ff});
   end

   // ---------------- planar radius ----------------
   logic [P-1:0]           root3;
   logic [P:0]             rem3;
   logic                   v3;
   logic signed [RW_W-1:0] w3;

   arm_ik_isqrt #(.W(2 * P)) u_sqrt_radius (
      .clock (clock), .din (sq2_ff), .root (root3), .rem (rem3)
   );

   arm_ik_delay #(.WIDTH(RW_W + 1), .DEPTH(P)) u_dly_w (
      .clock (clock), .reset (reset), .din ({v2_ff, w2_ff}), .dout ({v3, w3})
   );

   // ---------------- stage 4: horizontal reach ----------------
   logic                   v4_ff;
   logic signed [RW_W-1:0] u4_ff, w4_ff;
   logic                   round_up;

   assign round_up = (rem3 > {1'b0, root3});

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3;
   end

   always_ff @(posedge clock) begin
      u4_ff <= $signed({{(RW_W-P){1'b0}}, root3})
             + $signed({{(RW_W-1){1'b0}}, round_up})
             - $signed({{(RW_W-CFG_W){1'b0}}, shoulder_offset_ff})
             - $signed({{(RW_W-CFG_W){1'b0}}, tool_offset_ff});
      w4_ff <= w3;
   end

   // ---------------- stage 5: range check, s^2 ----------------
   logic                    v5_ff, ok5_ff;
   logic signed [ARM_W-1:0] u5_ff, w5_ff;
   logic [S2_W-1:0]         s2_5_ff;
   logic signed [ARM_W-1:0] u4n, w4n;
   logic signed [30:0]      usq, wsq, s2sum;
   logic                    in_range;

   assign u4n      = u4_ff[ARM_W-1:0];
   assign w4n      = w4_ff[ARM_W-1:0];
   assign usq      = u4n * u4n;
   assign wsq      = w4n * w4n;
   assign s2sum    = usq + wsq;
   assign in_range = (u4_ff < LIM_POS) && (u4_ff > LIM_NEG)
                  && (w4_ff < LIM_POS) && (w4_ff > LIM_NEG);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         ok5_ff <= 1'b0;
      end else begin
         v5_ff  <= v4_ff;
         ok5_ff <= in_range && (lower_len_ff != '0) && (upper_len_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      u5_ff   <= u4n;
      w5_ff   <= w4n;
      s2_5_ff <= s2sum[S2_W-1:0];
   end

   // phi = atan2(w, u)
   logic signed [ANG_W-1:0] phi_c, phi10;

   arm_ik_cordic #(.IN_W(ARM_W), .STAGES(CORDIC_STAGES)) u_cordic_phi (
      .clock (clock), .din_y (w5_ff), .din_x (u5_ff), .angle (phi_c)
   );

   arm_ik_delay #(.WIDTH(ANG_W), .DEPTH(32)) u_dly_phi (
      .clock (clock), .reset (reset), .din (phi_c), .dout (phi10)
   );

   // ---------------- stage 6: law of cosines numerators ----------------
   logic                  v6_ff, ok6_ff;
   logic signed [N_W-1:0] nl6_ff, nu6_ff;
   logic [S2_W-1:0]       s2_6_ff;
   logic signed [N_W-1:0] s2_s, lsq_s, usq_s;

   assign s2_s  = $signed({{(N_W-S2_W){1'b0}}, s2_5_ff});
   assign lsq_s = $signed({{(N_W-LEN2_W){1'b0}}, lower_sq_ff});
   assign usq_s = $signed({{(N_W-LEN2_W){1'b0}}, upper_sq_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         ok6_ff <= 1'b0;
      end else begin
         v6_ff  <= v5_ff;
         ok6_ff <= ok5_ff && (s2_5_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      nl6_ff  <= s2_s + lsq_s - usq_s;
      nu6_ff  <= s2_s + usq_s - lsq_s;
      s2_6_ff <= s2_5_ff;
   end

   // ---------------- stage 7: products ----------------
   logic                  v7_ff, ok7_ff;
   logic [P_W-1:0]        pl7_ff, pu7_ff;
   logic signed [R_W-1:0] ql7_ff, qu7_ff;
   logic signed [N_W-1:0] nl7_ff, nu7_ff;
   logic signed [R_W-1:0] nl_ext, nu_ext;

   assign nl_ext = R_W'(nl6_ff);
   assign nu_ext = R_W'(nu6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         ok7_ff <= 1'b0;
      end else begin
         v7_ff  <= v6_ff;
         ok7_ff <= ok6_ff;
      end
   end

   always_ff @(posedge clock) begin
      pl7_ff <= lower_sq_ff * s2_6_ff;
      pu7_ff <= upper_sq_ff * s2_6_ff;
      ql7_ff <= nl_ext * nl_ext;
      qu7_ff <= nu_ext * nu_ext;
      nl7_ff <= nl6_ff;
      nu7_ff <= nu6_ff;
   end

   // ---------------- stage 8: acos radicands ----------------
   logic                  v8_ff, ok8_ff;
   logic signed [R_W-1:0] rl8_ff, ru8_ff;
   logic signed [N_W-1:0] nl8_ff, nu8_ff;
   logic signed [R_W-1:0] rl_in, ru_in;

   assign rl_in = $signed({{(R_W-P_W-2){1'b0}}, pl7_ff, 2'b00}) - ql7_ff;
   assign ru_in = $signed({{(R_W-P_W-2){1'b0}}, pu7_ff, 2'b00}) - qu7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff  <= 1'b0;
         ok8_ff <= 1'b0;
      end else begin
         v8_ff  <= v7_ff;
         // drop the solution when either acos argument leaves [-1, 1]
         ok8_ff <= ok7_ff && !rl_in[R_W-1] && !ru_in[R_W-1];
      end
   end

   always_ff @(posedge clock) begin
      rl8_ff <= rl_in;
      ru8_ff <= ru_in;
      nl8_ff <= nl7_ff;
      nu8_ff <= nu7_ff;
   end

   // ---------------- acos via atan2(sqrt(radicand), numerator) ----------------
   logic [ROOT2_W-1:0]    rootl9, rootu9;
   logic signed [N_W-1:0] nl9, nu9;
   logic                  v10, ok10;

   arm_ik_isqrt #(.W(RAD_W)) u_sqrt_lower (
      .clock (clock), .din (rl8_ff[RAD_W-1:0]), .root (rootl9), .rem ()
   );

   arm_ik_isqrt #(.W(RAD_W)) u_sqrt_upper (
      .clock (clock), .din (ru8_ff[RAD_W-1:0]), .root (rootu9), .rem ()
   );

   arm_ik_delay #(.WIDTH(2 * N_W), .DEPTH(ROOT2_W)) u_dly_num (
      .clock (clock), .reset (reset), .din ({nl8_ff, nu8_ff}), .dout ({nl9, nu9})
   );

   arm_ik_delay #(.WIDTH(2), .DEPTH(ROOT2_W + LC)) u_dly_ok (
      .clock (clock), .reset (reset), .din ({v8_ff, ok8_ff}), .dout ({v10, ok10})
   );

   logic signed [ANG_W-1:0] acl10, acu10;

   arm_ik_cordic #(.IN_W(N_W), .STAGES(CORDIC_STAGES)) u_cordic_lower (
      .clock (clock),
      .din_y ($signed({{(N_W-ROOT2_W){1'b0}}, rootl9})),
      .din_x (nl9),
      .angle (acl10)
   );

   arm_ik_cordic #(.IN_W(N_W), .STAGES(CORDIC_STAGES)) u_cordic_upper (
      .clock (clock),
      .din_y ($signed({{(N_W-ROOT2_W){1'b0}}, rootu9})),
      .din_x (nu9),
      .angle (acu10)
   );

   // ---------------- output register ----------------
   logic                    rsp_valid_ff, rsp_ok_ff;
   logic signed [ANG_W-1:0] base_ff, lower_ff, upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_ok_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= v10;
         rsp_ok_ff    <= v10 && ok10;
      end
   end

   always_ff @(posedge clock) begin
      if (ok10) begin
         base_ff  <= yzero10 ? ANGLE_90 : base10;
         lower_ff <= acl10 + phi10;
         upper_ff <= acu10 - phi10;
      end else begin
         base_ff  <= '0;
         lower_ff <= '0;
         upper_ff <= '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_solution_ok     = rsp_ok_ff;
   assign rsp_base_angle      = base_ff;
   assign rsp_lower_arm_angle = lower_ff;
   assign rsp_upper_arm_angle = upper_ff;

   // ---------------- assertions ----------------
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without an item taken LAT cycles earlier");

   a_ok_needs_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_solution_ok)
      else $error("solution_ok raised outside a result cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_solution_ok) |->
         (rsp_base_angle == '0 && rsp_lower_arm_angle == '0 && rsp_upper_arm_angle == '0))
      else $error("angles not cleared on a failed solution");

endmodule

// ===== tb/arm_inverse_kinematics_3dof_top_test.sv =====
`timescale 1ns / 100ps

module arm_inverse_kinematics_3dof_top_test import arm_ik_pkg::*;;

   localparam int PW = 17;
   localparam int STAGES = 16;
   localparam int LATENCY = PW + STAGES + 39;

   typedef struct {
      logic [ANG_W-1:0] base;
      logic [ANG_W-1:0] lower;
      logic [ANG_W-1:0] upper;
      logic             ok;
   } joint_angles_type;

   class joint_scoreboard_type;
      longint unsigned    arm_reg[7];
      joint_angles_type   pending[$];
      int                 errors;

      function new();
         arm_reg = '{1706, 211, 2273, 2541, 1193, 905, 2};
         errors = 0;
      endfunction

      function automatic longint unsigned root_floor(longint unsigned v,
                                                     output longint unsigned rem);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         rem = v;
         return r;
      endfunction

      // vectoring rotation, result in 1/256 degree
      function automatic longint heading(longint yv, longint xv);
         longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115};
         longint x, y, z, t, dx, dy;
         x = xv * 65536;
         y = yv * 65536;
         z = 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = 90 * 65536;
            end else begin
               x = -y; y = t; z = -90 * 65536;
            end
         end
         for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += tab[i];
            end else begin
               x -= dx; y += dy; z -= tab[i];
            end
         end
         return (z + 128) >>> 8;
      endfunction

      function automatic bit cosine_angle(longint s2, longint a, longint b,
                                          output longint ang);
         longint n, r;
         longint unsigned rem;
         n = s2 + a * a - b * b;
         r = 4 * a * a * s2 - n * n;
         ang = 0;
         if (r < 0) return 0;
         ang = heading(longint'(root_floor(longint'(r), rem)), n);
         return 1;
      endfunction

      function void note_target(longint x, longint y, longint z);
         longint lo, up, base, u, w, s2, phi, acl, acu, la, ua;
         longint unsigned rem, r;
         bit ok;
         joint_angles_type e;
         lo = arm_reg[CSR_LOWER_ARM];
         up = arm_reg[CSR_UPPER_ARM];
         acl = 0; acu = 0; la = 0; ua = 0; ok = 1;
         if (x < longint'(arm_reg[CSR_MIN_REACH_X])) x = arm_reg[CSR_MIN_REACH_X];
         base = (y == 0) ? 23040 : heading(x, -y);
         r = root_floor(longint'(x * x + y * y), rem);
         if (rem > r) r++;
         u = longint'(r) - longint'(arm_reg[CSR_SHOULDER_OFFSET])
             - longint'(arm_reg[CSR_TOOL_OFFSET]);
         w = z + longint'(arm_reg[CSR_Z_OFFSET]) - longint'(arm_reg[CSR_BASE_HEIGHT]);
         if (u >= REACH_LIMIT || u <= -REACH_LIMIT || w >= REACH_LIMIT ||
             w <= -REACH_LIMIT) ok = 0;
         if (lo == 0 || up == 0) ok = 0;
         if (ok) begin
            s2 = u * u + w * w;
            if (s2 == 0) ok = 0;
            else if (!cosine_angle(s2, lo, up, acl) || !cosine_angle(s2, up, lo, acu))
               ok = 0;
         end
         if (ok) begin
            phi = heading(w, u);
            la = acl + phi;
            ua = acu - phi;
         end else begin
            base = 0;
         end
         e.base = base[ANG_W-1:0];
         e.lower = la[ANG_W-1:0];
         e.upper = ua[ANG_W-1:0];
         e.ok = ok;
         pending.push_back(e);
      endfunction

      task report(string what);
         $display("%0t: mismatch: %s", $time, what);
         errors++;
      endtask

      task check_angles(joint_angles_type got);
         joint_angles_type e;
         if (pending.size() == 0) begin
            report("result with nothing pending");
            return;
         end
         e = pending.pop_front();
         if (got.base !== e.base)
            report($sformatf("base_angle got %0h want %0h", got.base, e.base));
         if (got.lower !== e.lower)
            report($sformatf("lower_arm_angle got %0h want %0h", got.lower, e.lower));
         if (got.upper !== e.upper)
            report($sformatf("upper_arm_angle got %0h want %0h", got.upper, e.upper));
         if (got.ok !== e.ok)
            report($sformatf("solution_ok got %0b want %0b", got.ok, e.ok));
      endtask
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic signed [PW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic                 rsp_valid;
   logic signed [ANG_W-1:0] rsp_base_angle, rsp_lower_arm_angle, rsp_upper_arm_angle;
   logic                 rsp_solution_ok;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   joint_scoreboard_type sb = new();
   int idle_pct;

   arm_inverse_kinematics_3dof_top #(.POS_WIDTH(PW), .CORDIC_STAGES(STAGES)) u_dut (
      .clock, .reset, .start, .busy, .req_pos_x, .req_pos_y, .req_pos_z,
      .rsp_valid, .rsp_base_angle, .rsp_lower_arm_angle, .rsp_upper_arm_angle,
      .rsp_solution_ok, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      joint_angles_type got;
      if (!reset && rsp_valid) begin
         got.base = rsp_base_angle;
         got.lower = rsp_lower_arm_angle;
         got.upper = rsp_upper_arm_angle;
         got.ok = rsp_solution_ok;
         sb.check_angles(got);
      end
   end

   task send_target(longint x, longint y, longint z);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 0;
      end
      @(negedge clock);
      start = 1;
      req_pos_x = x[PW-1:0];
      req_pos_y = y[PW-1:0];
      req_pos_z = z[PW-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_target(longint'(req_pos_x), longint'(req_pos_y), longint'(req_pos_z));
   endtask

   task drain();
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      // wait out anything still in flight before touching registers
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, longint unsigned value);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.arm_reg[idx] = (idx == CSR_MIN_REACH_X) ? value & 8'hFF : value & 13'h1FFF;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task write_all(longint unsigned bh, longint unsigned so, longint unsigned lo,
                  longint unsigned up, longint unsigned zo, longint unsigned to,
                  longint unsigned mr);
      write_reg(CSR_BASE_HEIGHT, bh);
      write_reg(CSR_SHOULDER_OFFSET, so);
      write_reg(CSR_LOWER_ARM, lo);
      write_reg(CSR_UPPER_ARM, up);
      write_reg(CSR_Z_OFFSET, zo);
      write_reg(CSR_TOOL_OFFSET, to);
      write_reg(CSR_MIN_REACH_X, mr);
   endtask

   function automatic longint pick_coord();
      case ($urandom_range(9))
         0, 1, 2: return longint'($urandom_range(131071)) - 65536;
         3:       return longint'($urandom_range(255)) - 128;
         default: return longint'($urandom_range(12000)) - 6000;
      endcase
   endfunction

   task random_targets(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         send_target(pick_coord(), pick_coord(), pick_coord());
      end
   endtask

   initial begin
      idle_pct = 12;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // extremes, y zero, clamped x, reach behind shoulder, zero reach, out of reach
      send_target(0, 0, 0);
      send_target(-65536, -65536, -65536);
      send_target(65535, 65535, 65535);
      send_target(65535, -65536, 0);
      send_target(-65536, 65535, 0);
      send_target(3000, 0, 500);
      send_target(-3000, 0, 500);
      send_target(1, -3000, 513);
      send_target(-200, 2500, 513);
      send_target(1116, 0, 513);
      send_target(100, 100, 513);
      send_target(20, -30, 2000);
      send_target(2500, -2500, 1000);
      send_target(2500, 2500, -1000);
      send_target(4000, -1, 513);
      send_target(4000, 1, 513);
      send_target(0, 20000, 0);
      send_target(-1, -1, -1);
      send_target(1500, -3500, 3000);
      send_target(3500, 1500, -3000);
      drain();
      random_targets(190);
      drain();

      write_all(8191, 8191, 8191, 8191, 8191, 8191, 255);
      send_target(254, 0, 0);
      send_target(-65536, 20000, 0);
      random_targets(190);
      drain();

      idle_pct = 88;
      write_all(0, 0, 1, 1, 0, 0, 0);
      send_target(1, 0, 0);
      send_target(0, 1, 1);
      random_targets(190);
      drain();

      write_all($urandom_range(8191), $urandom_range(4000), $urandom_range(8191, 1),
                $urandom_range(8191, 1), $urandom_range(8191), $urandom_range(4000),
                $urandom_range(255));
      random_targets(190);
      drain();

      idle_pct = 0;
      write_all(1706, 211, 0, 2541, 1193, 905, 2);
      random_targets(40);
      drain();
      write_all(1706, 211, 2273, 0, 1193, 905, 2);
      random_targets(40);
      drain();

      write_all(1706, 211, 2273, 2541, 1193, 905, 2);
      random_targets(390);
      drain();

      if (sb.errors == 0) begin
         $display("arm_inverse_kinematics_3dof_top_test passed");
      end else begin
         $display("arm_inverse_kinematics_3dof_top_test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("arm_inverse_kinematics_3dof_top_test failed");
      $finish;
   end

endmodule
